>>> rtl/core/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg
// Shared constants, types and stage structs of the 3x3 neighbor mean smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package nms_pkg;

   // Largest grid side the line stores hold.
   localparam int MAX_SIDE  = 2048;
   localparam int COL_W     = $clog2(MAX_SIDE);
   // The side itself, 2..MAX_SIDE.
   localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
   // Row count runs up to MAX_SIDE + 1 while the tail drains.
   localparam int ROW_W     = $clog2(MAX_SIDE + 2);
   localparam int SIDE_MIN  = 2;

   localparam int CFG_W     = 12;
   localparam int CFG_RESET = 400;

   localparam int H_W       = 20;
   localparam int NBR_N     = 8;
   localparam int SUM_W     = H_W + 3;
   localparam int CNT_W     = 4;

   // Reciprocals for exact division of values below 2**SUM_W by 3, 5 and 8.
   localparam int RECIP_SHIFT = SUM_W + 3;
   localparam int RECIP_W     = RECIP_SHIFT - 1;
   localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2 ** RECIP_SHIFT + 2) / 3);
   localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((2 ** RECIP_SHIFT + 4) / 5);
   localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'((2 ** RECIP_SHIFT) / 8);
   localparam int PROD_W      = SUM_W + RECIP_W;

   // Output queue; the depth must be a power of two.
   localparam int QDEPTH  = 16;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef logic signed [H_W-1:0] height_type;

   // One item entering the line stores.
   typedef struct packed {
      logic             valid;
      logic [COL_W-1:0] col;
      height_type       height;
      logic             col_zero;
      logic             left_ok;
      logic             right_ok;
      logic             top_ok;
      logic             bot_ok;
      logic             produce;
      logic             last;
   } ent_type;

   // Masked neighbors of one output point.
   typedef struct packed {
      logic                       valid;
      logic [NBR_N-1:0][H_W-1:0]  vals;
      logic [CNT_W-1:0]           cnt;
      logic                       last;
   } nbr_type;

   // One finished result.
   typedef struct packed {
      logic       valid;
      height_type height;
      logic       last;
   } res_type;

endpackage

`default_nettype wire

>>> rtl/core/nms_ifs.sv
// ----------------------------------------------------------------------------
// nms_ifs
// Valid/ready channel interfaces of the smoother: samples, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface nms_req_if;
   import nms_pkg::*;
   logic             valid;
   logic             ready;
   logic             command;
   logic [H_W-1:0]   height_in;
   modport source (output valid, command, height_in, input ready);
   modport sink   (input valid, command, height_in, output ready);
endinterface

interface nms_rsp_if;
   import nms_pkg::*;
   logic             valid;
   logic             ready;
   logic [H_W-1:0]   height_out;
   logic             last;
   modport source (output valid, height_out, last, input ready);
   modport sink   (input valid, height_out, last, output ready);
endinterface

interface nms_csr_if;
   import nms_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] grid_side;
   modport source (output valid, grid_side, input ready);
   modport sink   (input valid, grid_side, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nms_ram.sv
// ----------------------------------------------------------------------------
// nms_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/nms_window.sv
// ----------------------------------------------------------------------------
// nms_window
// Line stores and 3x3 sample window; picks the in-grid neighbors of a point.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_window (
   input  logic             clock,
   input  logic             reset,
   input  nms_pkg::ent_type ent,
   output nms_pkg::nbr_type nbr
);
   import nms_pkg::*;

   ent_type                      s1_ff;
   logic [H_W-1:0]               upper_rd;
   logic [H_W-1:0]               middle_rd;
   logic [2:0][2:0][H_W-1:0]     win_ff;
   logic [2:0][2:0][H_W-1:0]     win_in;
   logic [2:0][2:0][H_W-1:0]     sel;
   logic [NBR_N-1:0]             mask;
   logic [NBR_N-1:0][H_W-1:0]    pick;
   nbr_type                      nbr_ff;
   nbr_type                      nbr_in;

   // The read is issued as the item is taken; the write back of the same
   // column follows in the next cycle, before any later item reaches it again.
   nms_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_upper (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_ff.col),
      .wr_data (middle_rd),
      .rd_en   (ent.valid),
      .rd_addr (ent.col),
      .rd_data (upper_rd)
   );

   nms_ram #(.WIDTH(H_W), .DEPTH(MAX_SIDE)) u_middle (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.height),
      .rd_en   (ent.valid),
      .rd_addr (ent.col),
      .rd_data (middle_rd)
   );

   always_comb begin
      for (int dr = 0; dr < 3; dr++) begin
         win_in[dr][0] = win_ff[dr][1];
         win_in[dr][1] = win_ff[dr][2];
      end
      win_in[0][2] = upper_rd;
      win_in[1][2] = middle_rd;
      win_in[2][2] = s1_ff.height;

      // At column zero the point is the last column of the previous row,
      // which sits in the window as it stood before this shift.
      for (int dr = 0; dr < 3; dr++) begin
         if (s1_ff.col_zero) begin
            sel[dr][0] = win_ff[dr][1];
            sel[dr][1] = win_ff[dr][2];
            sel[dr][2] = '0;
         end else begin
            sel[dr] = win_in[dr];
         end
      end

      pick[0] = sel[0][0];
      pick[1] = sel[0][1];
      pick[2] = sel[0][2];
      pick[3] = sel[1][0];
      pick[4] = sel[1][2];
      pick[5] = sel[2][0];
      pick[6] = sel[2][1];
      pick[7] = sel[2][2];

      mask[0] = s1_ff.top_ok && s1_ff.left_ok;
      mask[1] = s1_ff.top_ok;
      mask[2] = s1_ff.top_ok && s1_ff.right_ok;
      mask[3] = s1_ff.left_ok;
      mask[4] = s1_ff.right_ok;
      mask[5] = s1_ff.bot_ok && s1_ff.left_ok;
      mask[6] = s1_ff.bot_ok;
      mask[7] = s1_ff.bot_ok && s1_ff.right_ok;

      nbr_in.valid = s1_ff.valid && s1_ff.produce;
      nbr_in.last  = s1_ff.last;
      nbr_in.cnt   = CNT_W'($countones(mask));
      for (int i = 0; i < NBR_N; i++) begin
         nbr_in.vals[i] = mask[i] ? pick[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         nbr_ff.valid <= 1'b0;
         win_ff       <= '0;
      end else begin
         s1_ff.valid  <= ent.valid;
         nbr_ff.valid <= nbr_in.valid;
         if (s1_ff.valid) begin
            win_ff <= win_in;
         end
      end
      s1_ff.col      <= ent.col;
      s1_ff.height   <= ent.height;
      s1_ff.col_zero <= ent.col_zero;
      s1_ff.left_ok  <= ent.left_ok;
      s1_ff.right_ok <= ent.right_ok;
      s1_ff.top_ok   <= ent.top_ok;
      s1_ff.bot_ok   <= ent.bot_ok;
      s1_ff.produce  <= ent.produce;
      s1_ff.last     <= ent.last;
      nbr_ff.vals    <= nbr_in.vals;
      nbr_ff.cnt     <= nbr_in.cnt;
      nbr_ff.last    <= nbr_in.last;
   end

   assign nbr = nbr_ff;

endmodule

`default_nettype wire

>>> rtl/core/nms_mean.sv
// ----------------------------------------------------------------------------
// nms_mean
// Sums the masked neighbors and divides by their count, rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_mean (
   input  logic             clock,
   input  logic             reset,
   input  nms_pkg::nbr_type nbr,
   output nms_pkg::res_type res
);
   import nms_pkg::*;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] cnt;
      logic             last;
   } meta_type;

   meta_type                m3_ff, m4_ff, m5_ff, m6_ff;
   logic signed [SUM_W-1:0] pair_in [4];
   logic signed [SUM_W-1:0] pair_ff [4];
   logic signed [SUM_W-1:0] sum_in, sum_ff;
   logic [SUM_W-1:0]        mag_in, mag_ff;
   logic                    neg5_ff, neg6_ff;
   logic [RECIP_W-1:0]      recip;
   logic [PROD_W-1:0]       prod_in, prod_ff;
   logic [H_W-1:0]          quo;
   res_type                 res_ff;
   res_type                 res_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pair_in[i] = SUM_W'($signed(nbr.vals[2*i])) + SUM_W'($signed(nbr.vals[2*i+1]));
      end
      sum_in = pair_ff[0] + pair_ff[1] + pair_ff[2] + pair_ff[3];

      // Magnitude plus half the count; the sign is put back after division,
      // which rounds ties away from zero.
      mag_in = (sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff))
               + SUM_W'(m4_ff.cnt >> 1);

      unique case (m5_ff.cnt)
         CNT_W'(3): recip = RECIP_3;
         CNT_W'(5): recip = RECIP_5;
         default:   recip = RECIP_8;
      endcase
      prod_in = PROD_W'(mag_ff) * PROD_W'(recip);

      quo           = prod_ff[RECIP_SHIFT +: H_W];
      res_in.valid  = m6_ff.valid;
      res_in.last   = m6_ff.last;
      res_in.height = neg6_ff ? -$signed(quo) : $signed(quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_ff.valid  <= 1'b0;
         m4_ff.valid  <= 1'b0;
         m5_ff.valid  <= 1'b0;
         m6_ff.valid  <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         m3_ff.valid  <= nbr.valid;
         m4_ff.valid  <= m3_ff.valid;
         m5_ff.valid  <= m4_ff.valid;
         m6_ff.valid  <= m5_ff.valid;
         res_ff.valid <= res_in.valid;
      end
      m3_ff.cnt     <= nbr.cnt;
      m3_ff.last    <= nbr.last;
      m4_ff.cnt     <= m3_ff.cnt;
      m4_ff.last    <= m3_ff.last;
      m5_ff.cnt     <= m4_ff.cnt;
      m5_ff.last    <= m4_ff.last;
      m6_ff.cnt     <= m5_ff.cnt;
      m6_ff.last    <= m5_ff.last;
      for (int i = 0; i < 4; i++) begin
         pair_ff[i] <= pair_in[i];
      end
      sum_ff        <= sum_in;
      mag_ff        <= mag_in;
      neg5_ff       <= sum_ff[SUM_W-1];
      neg6_ff       <= neg5_ff;
      prod_ff       <= prod_in;
      res_ff.height <= res_in.height;
      res_ff.last   <= res_in.last;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

>>> rtl/core/nms_outq.sv
// ----------------------------------------------------------------------------
// nms_outq
// Result queue that decouples the filter pipeline from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_outq (
   input  logic             clock,
   input  logic             reset,
   input  nms_pkg::res_type push,
   nms_rsp_if.source        rsp
);
   import nms_pkg::*;

   typedef struct packed {
      height_type height;
      logic       last;
   } qent_type;

   qent_type [QDEPTH-1:0] mem_ff;
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                  pop;

   assign rsp.valid      = (cnt_ff != '0);
   assign rsp.height_out = mem_ff[rd_ptr_ff].height;
   assign rsp.last       = mem_ff[rd_ptr_ff].last;
   assign pop            = rsp.valid && rsp.ready;

   // No overflow check: the top level only takes an item while a slot is free.
   always_comb begin
      wr_ptr_in = push.valid ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff].height <= push.height;
         mem_ff[wr_ptr_ff].last   <= push.last;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/neighbor_mean_smoother_3x3.sv
// ----------------------------------------------------------------------------
// neighbor_mean_smoother_3x3
// Streaming mean of the in-grid 8-neighbors over a raster-ordered height grid.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                     Taken when
//   req      in   command, height_in (Q12.8)  req.valid && req.ready
//   rsp      out  height_out (Q12.8), last    rsp.valid && rsp.ready
//   csr      in   grid_side (12 bits)         csr.valid && csr.ready
//
// One item per clock while req.ready is high. Each item reads and writes back
// one column of the two line stores, so the store ports set the rate; a result
// reaches rsp via the window, mean and queue registers once the item that
// completes its window is taken. Each item yielding a result reserves one of
// 16 queue slots; req.ready drops only once 16 are in flight or waiting on rsp.
// Reset is synchronous; grid_side comes up as 400 and the line stores are not
// cleared. csr is always ready and restarts the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_mean_smoother_3x3 (
   input  logic      clock,
   input  logic      reset,
   nms_req_if.sink   req,
   nms_rsp_if.source rsp,
   nms_csr_if.sink   csr
);
   import nms_pkg::*;

   localparam int SIDE_RST = (CFG_RESET > MAX_SIDE) ? MAX_SIDE : CFG_RESET;

   logic [SIDE_W-1:0] side_ff, side_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [QCNT_W-1:0] pend_ff, pend_in;
   logic [ROW_W-1:0]  side_row;
   logic              req_fire;
   logic              full;
   logic              take;
   logic              col_zero;
   logic              col_last;
   logic              produce;
   logic              grid_end;
   ent_type           ent;
   nbr_type           nbr;
   res_type           res;

   assign csr.ready = 1'b1;
   assign req.ready = (pend_ff < QCNT_W'(QDEPTH));
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      side_row = ROW_W'(side_ff);
      full     = (row_ff >= side_row);
      // A sample after the grid is complete, or a flush before, is dropped.
      take     = req_fire && (req.command ? full : !full);
      col_zero = (col_ff == '0);
      col_last = (col_ff == COL_W'(side_ff - SIDE_W'(1)));
      produce  = !((row_ff == '0) || ((row_ff == ROW_W'(1)) && col_zero));
      grid_end = (row_ff == side_row + ROW_W'(1)) && col_zero;

      ent.valid    = take;
      ent.col      = col_ff;
      ent.height   = req.command ? '0 : $signed(req.height_in);
      ent.col_zero = col_zero;
      ent.left_ok  = col_zero || (col_ff >= COL_W'(2));
      ent.right_ok = !col_zero;
      ent.top_ok   = col_zero ? (row_ff >= ROW_W'(3)) : (row_ff >= ROW_W'(2));
      ent.bot_ok   = col_zero ? (row_ff <= side_row) : (row_ff < side_row);
      ent.produce  = produce;
      ent.last     = grid_end;
   end

   always_comb begin
      side_in = side_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr.valid) begin
         if (int'(csr.grid_side) < SIDE_MIN) begin
            side_in = SIDE_W'(SIDE_MIN);
         end else if (int'(csr.grid_side) > MAX_SIDE) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(csr.grid_side);
         end
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (grid_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_last) begin
            col_in = '0;
            row_in = ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
      pend_in = pend_ff + QCNT_W'(take && produce) - QCNT_W'(rsp.valid && rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(SIDE_RST);
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else begin
         side_ff <= side_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   nms_window u_window (
      .clock (clock),
      .reset (reset),
      .ent   (ent),
      .nbr   (nbr)
   );

   nms_mean u_mean (
      .clock (clock),
      .reset (reset),
      .nbr   (nbr),
      .res   (res)
   );

   nms_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (res),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire
